// ----- hdl/sida_pkg.sv -----
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants and types for the signed integer to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package sida_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DABBLE,
      OP_DIGIT
   } unit_op_type;

   typedef struct packed {
      unit_op_type op;
      logic        bit_in;
   } unit_ctrl_type;

endpackage

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per
// strobe, most significant digit first, minus sign in front if negative.
// ----------------------------------------------------------------------------
// Operation: after the start transfer the magnitude is converted by the bit-serial
//   double-dabble pass through the shared BCD unit, leading zero digits are
//   skipped, then the minus sign (if negative) and the digits are output, each
//   character registered. A new number is accepted only back in idle, once the
//   last character of the previous one has been output.
// Reset: synchronous; returns to idle, no strobe. Results cannot be stalled.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_char_code,
   output logic                          rsp_last
);
   import sida_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONVERT,
      S_SKIP,
      S_SIGN,
      S_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in, bcd_next;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic                     strobe_ff, strobe_in;
   logic [7:0]               char_ff, char_in;
   logic                     last_ff, last_in;

   unit_ctrl_type            unit_ctrl;
   logic [VALUE_WIDTH-1:0]   raw_value;
   logic [VALUE_WIDTH-1:0]   neg_value;
   logic [3:0]               top_digit;
   logic                     accept;

   assign raw_value = req_value[VALUE_WIDTH-1:0];
   assign neg_value = ~raw_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign accept    = start && (state_ff == S_IDLE);

   sida_bcd_unit u_bcd_unit (
      .ctrl    (unit_ctrl),
      .bcd_in  (bcd_ff),
      .bcd_out (bcd_next)
   );

   always_comb begin
      state_in         = state_ff;
      bcd_in           = bcd_next;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      strobe_in        = 1'b0;
      char_in          = char_ff;
      last_in          = last_ff;
      unit_ctrl.op     = OP_HOLD;
      unit_ctrl.bit_in = mag_ff[VALUE_WIDTH-1];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in   = raw_value[VALUE_WIDTH-1];
               mag_in   = raw_value[VALUE_WIDTH-1] ? neg_value : raw_value;
               bcd_in   = '0;
               cnt_in   = CNT_WIDTH'(VALUE_WIDTH - 1);
               state_in = S_CONVERT;
            end
         end
         S_CONVERT: begin
            unit_ctrl.op = OP_DABBLE;
            mag_in       = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in   = CNT_WIDTH'(NUM_DIGITS - 1);
               state_in = S_SKIP;
            end else begin
               cnt_in = cnt_ff - CNT_WIDTH'(1);
            end
         end
         S_SKIP: begin
            if ((top_digit == 4'd0) && (cnt_ff != '0)) begin
               unit_ctrl.op = OP_DIGIT;
               cnt_in       = cnt_ff - CNT_WIDTH'(1);
            end else begin
               state_in = neg_ff ? S_SIGN : S_EMIT;
            end
         end
         S_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CH_MINUS;
            last_in   = 1'b0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            unit_ctrl.op = OP_DIGIT;
            strobe_in    = 1'b1;
            char_in      = CH_ZERO + {4'd0, top_digit};
            last_in      = (cnt_ff == '0);
            if (cnt_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_WIDTH'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      bcd_ff  <= bcd_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after start transfer");

   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without work in progress");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_char_code == CH_MINUS)) |-> !rsp_last)
      else $error("minus sign marked last");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("still busy after last character");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_char_code != CH_MINUS)) |->
         ((rsp_char_code >= CH_ZERO) && (rsp_char_code <= (CH_ZERO + 8'd9))))
      else $error("character is not a decimal digit");
`endif

endmodule

// ----- hdl/sida_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// sida_bcd_unit
// Shared BCD shift unit: one double-dabble step (add 3, shift in a bit) or a
// whole-digit shift left, or passes the value through unchanged.
// ----------------------------------------------------------------------------
module sida_bcd_unit (
   input  sida_pkg::unit_ctrl_type            ctrl,
   input  logic [sida_pkg::BCD_WIDTH-1:0]     bcd_in,
   output logic [sida_pkg::BCD_WIDTH-1:0]     bcd_out
);
   import sida_pkg::*;

   logic [BCD_WIDTH-1:0] adjusted;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_in[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_in[4*i +: 4];
         end
      end
   end

   always_comb begin
      case (ctrl.op)
         OP_DABBLE: bcd_out = {adjusted[BCD_WIDTH-2:0], ctrl.bit_in};
         OP_DIGIT:  bcd_out = {bcd_in[BCD_WIDTH-5:0], 4'd0};
         default:   bcd_out = bcd_in;
      endcase
   end

endmodule
